@@ rtl/ffa_pkg.sv @@
// Package: shared constants and types for the first-fit allocator.
`timescale 1ns / 1ps
package ffa_pkg;
  localparam int TableEntries = 1024;
  localparam int IdxW = $clog2(TableEntries);
  localparam int CntW = IdxW + 1;
  localparam int OutCntW = 11;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_LOST   = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } region_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction
endpackage

@@ rtl/ffa_table.sv @@
// Region table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module ffa_table (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ffa_pkg::IdxW-1:0] waddr,
  input  ffa_pkg::region_t         wdata,
  input  logic [ffa_pkg::IdxW-1:0] raddr,
  output ffa_pkg::region_t         rdata
);
  import ffa_pkg::*;

  region_t mem [TableEntries];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/first_fit_free_list_allocator.sv @@
// Top level: first-fit free-list allocator with coalescing.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  input   | in_valid, in_stall, command,          | in
//          | region_addr, region_size              |
//  output  | out_valid, out_stall, alloc_addr,     | out
//          | status, free_total, entry_count, ...  |
//
// One command at a time. Alloc scans the table entry by entry, each step a
// read issue and then a compare through the registered read port; free scans
// to its slot the same way, then shifts the tail entry by entry (read, then
// write). The block returns to idle after the result is taken, before the
// next accept. Clear zeroes the count and statistics and goes to the result.
// Reset (rst, synchronous) empties the table; entries are never cleared since
// only entries below the count are read. in_stall is high while busy or while
// the result waits in the output register; out_stall holds the result.
`timescale 1ns / 1ps
module first_fit_free_list_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   command,
  input  logic [31:0]                  region_addr,
  input  logic [31:0]                  region_size,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [31:0]                  alloc_addr,
  output logic [1:0]                   status,
  output logic [31:0]                  free_total,
  output logic [ffa_pkg::OutCntW-1:0]  entry_count,
  output logic [ffa_pkg::OutCntW-1:0]  peak_count,
  output logic [31:0]                  lost_count,
  output logic [31:0]                  lost_bytes
);
  import ffa_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_ARD    = 10'b0000000010,  // alloc: read issued
    S_ACHK   = 10'b0000000100,  // alloc: compare
    S_FRD    = 10'b0000001000,  // free: read issued
    S_FCHK   = 10'b0000010000,  // free: compare start
    S_FPREV  = 10'b0000100000,  // shift-up: final insert write
    S_FNEXT  = 10'b0001000000,  // free: next entry data valid
    S_SHRD   = 10'b0010000000,  // shift: read issued
    S_SHWR   = 10'b0100000000,  // shift: write
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state;
  logic [31:0]     addr, size;
  logic [CntW-1:0] used, peak, k;
  logic [31:0]     run_free, lost_n, lost_b;
  region_t         prev_r, rdata, wdata;
  logic            have_prev, shift_up;
  logic [IdxW-1:0] raddr, waddr;
  logic            we;
  logic [CntW-1:0] sh_j, sh_end;   // shift cursor / stop
  region_t         ins_r;          // entry written at end of shift-up

  ffa_table u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [31:0] prev_end;
  assign prev_end = prev_r.start + prev_r.length;

  always_ff @(posedge clk) begin
    we <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      used <= '0; peak <= '0; run_free <= '0; lost_n <= '0; lost_b <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            addr <= region_addr; size <= region_size;
            k <= '0; have_prev <= 1'b0; alloc_addr <= '0; status <= ST_OK;
            case (cmd_t'(command))
              CMD_ALLOC: begin
                raddr <= '0;
                if (used == '0) begin
                  status <= ST_NOFIT; state <= S_DONE;
                end else state <= S_ARD;
              end
              CMD_FREE: begin
                raddr <= '0;
                state <= (used == '0) ? S_FNEXT : S_FRD;
              end
              CMD_CLEAR: begin
                used <= '0; peak <= '0; run_free <= '0; lost_n <= '0; lost_b <= '0;
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_ARD: state <= S_ACHK;
        S_ACHK: begin
          if (rdata.length >= size) begin
            alloc_addr <= rdata.start;
            run_free <= (run_free > size) ? run_free - size : '0;
            if (rdata.length == size) begin
              // remove entry k: shift tail down
              used <= used - 1'b1;
              sh_j <= k; sh_end <= used - 1'b1; shift_up <= 1'b0;
              raddr <= IdxW'(k + 1'b1);
              state <= (k + 1'b1 < used) ? S_SHRD : S_DONE;
            end else begin
              we <= 1'b1; waddr <= k[IdxW-1:0];
              wdata <= '{start: rdata.start + size, length: rdata.length - size};
              state <= S_DONE;
            end
          end else if (k + 1'b1 < used) begin
            k <= k + 1'b1; raddr <= IdxW'(k + 1'b1); state <= S_ARD;
          end else begin
            status <= ST_NOFIT; state <= S_DONE;
          end
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (rdata.start > addr) begin
            state <= S_FNEXT;  // rdata holds entry k
          end else begin
            prev_r <= rdata; have_prev <= 1'b1;
            if (k + 1'b1 < used) begin
              k <= k + 1'b1; raddr <= IdxW'(k + 1'b1); state <= S_FRD;
            end else begin
              k <= k + 1'b1; state <= S_FNEXT;
            end
          end
        end
        S_FNEXT: begin
          // k = slot; rdata = entry k when k < used
          if (have_prev && prev_end == addr) begin
            run_free <= sat_add(run_free, size);
            we <= 1'b1; waddr <= IdxW'(k - 1'b1);
            if (k < used && addr + size == rdata.start) begin
              wdata <= '{start: prev_r.start, length: prev_r.length + size + rdata.length};
              used <= used - 1'b1;
              sh_j <= k; sh_end <= used - 1'b1; shift_up <= 1'b0;
              raddr <= IdxW'(k + 1'b1);
              state <= (k + 1'b1 < used) ? S_SHRD : S_DONE;
            end else begin
              wdata <= '{start: prev_r.start, length: prev_r.length + size};
              state <= S_DONE;
            end
          end else if (k < used && addr + size == rdata.start) begin
            run_free <= sat_add(run_free, size);
            we <= 1'b1; waddr <= k[IdxW-1:0];
            wdata <= '{start: addr, length: rdata.length + size};
            state <= S_DONE;
          end else if (used < CntW'(TableEntries)) begin
            run_free <= sat_add(run_free, size);
            used <= used + 1'b1;
            if (peak < used + 1'b1) peak <= used + 1'b1;
            ins_r <= '{start: addr, length: size};
            shift_up <= 1'b1; sh_j <= used; sh_end <= k;
            if (used > k) begin
              raddr <= IdxW'(used - 1'b1); state <= S_SHRD;
            end else begin
              we <= 1'b1; waddr <= k[IdxW-1:0];
              wdata <= '{start: addr, length: size};
              state <= S_DONE;
            end
          end else begin
            lost_n <= sat_add(lost_n, 32'd1);
            lost_b <= sat_add(lost_b, size);
            status <= ST_LOST; state <= S_DONE;
          end
        end
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          we <= 1'b1; waddr <= sh_j[IdxW-1:0]; wdata <= rdata;
          if (shift_up) begin
            if (sh_j - 1'b1 > sh_end) begin
              sh_j <= sh_j - 1'b1; raddr <= IdxW'(sh_j - 2'd2); state <= S_SHRD;
            end else begin
              sh_j <= sh_j - 1'b1; state <= S_FPREV;
            end
          end else begin
            if (sh_j + 1'b1 < sh_end) begin
              sh_j <= sh_j + 1'b1; raddr <= IdxW'(sh_j + 2'd2); state <= S_SHRD;
            end else state <= S_DONE;
          end
        end
        S_FPREV: begin
          // final insert write after shift-up
          we <= 1'b1; waddr <= sh_end[IdxW-1:0]; wdata <= ins_r;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            free_total <= run_free; entry_count <= OutCntW'(used);
            peak_count <= OutCntW'(peak); lost_count <= lost_n; lost_bytes <= lost_b;
          end else if (!out_stall) begin
            out_valid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);

  // Never accept while a result is pending.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("accept while result pending");
  // Table never exceeds its capacity.
  a_used_cap: assert property (@(posedge clk) disable iff (rst)
    used <= CntW'(TableEntries)) else $error("entry count overflow");
  // Peak never below current count at result.
  a_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (peak_count >= entry_count)) else $error("peak below count");
endmodule
